[rtl/hme_pkg.sv]
// package for the master-election engine: shared types and constants
// used by hme_cell and heartbeat_master_election
package hme_pkg;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] PEER_PENDING   = 2'd0;
  localparam logic [1:0] PEER_READY     = 2'd1;
  localparam logic [1:0] PEER_DESTROYED = 2'd2;

  localparam logic [2:0] REG_SELF_ID    = 3'd0;
  localparam logic [2:0] REG_SELF_SEC   = 3'd1;
  localparam logic [2:0] REG_SELF_NANOS = 3'd2;
  localparam logic [2:0] REG_PEND_LIMIT = 3'd3;
  localparam logic [2:0] REG_SYNC_LIMIT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic hit;
    logic free;
  } scan_t;

endpackage

[rtl/hme_cell.sv]
// one neighbor table entry: holds a peer id and valid bit, checks the
// key against its entry and passes the search token on; uses hme_pkg
module hme_cell import hme_pkg::*; #(
  parameter int ID_W = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] key,
  input  scan_t           scan_in,
  input  logic            start,
  input  logic            shift,
  input  logic            wr_en,
  input  logic            wr_valid,
  output scan_t           scan_out,
  output logic            my_hit,
  output logic            my_free,
  output logic            valid
);

  logic            valid_r;
  logic [ID_W-1:0] peer_r;
  scan_t           tok_r;

  assign valid    = valid_r;
  assign scan_out = tok_r;

  // first hit stops the chain's free search from this point on
  assign my_hit  = shift && !scan_in.hit && valid_r && peer_r == key;
  assign my_free = shift && !scan_in.hit && !scan_in.free && !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (start) begin
        tok_r <= '0;
      end else if (shift) begin
        tok_r.hit  <= scan_in.hit | my_hit;
        tok_r.free <= scan_in.free | my_free;
      end
      if (wr_en) begin
        valid_r <= wr_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_valid) begin
      peer_r <= key;
    end
  end

endmodule

[rtl/heartbeat_master_election.sv]
// master-election engine with a chain of neighbor table cells
// a tick or own-id item goes from idle to the output state; a peer item steps
// through the scan and write states first; one item at a time, a new one is taken
// only once the result is taken; the search token walks one cell per cycle;
// result held in an output register until taken
// reset empties the table and restores the register defaults
module heartbeat_master_election import hme_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [ID_WIDTH-1:0] in_peer_id,
  input  logic [1:0]          in_peer_state,
  input  logic [ID_WIDTH-1:0] in_peer_master_id,
  input  logic                in_peer_master_valid,
  input  logic [31:0]         in_peer_init_seconds,
  input  logic [29:0]         in_peer_init_nanos,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_node_state,
  output logic [ID_WIDTH-1:0] out_master_id,
  output logic                out_master_valid,
  output logic                out_publish_status,
  output logic                out_replay_request,
  output logic [4:0]          out_neighbor_count,
  output logic                out_table_overflow
);

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int IXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [15:0] self_id_r;
  logic [31:0] self_sec_r;
  logic [29:0] self_nanos_r;
  logic [15:0] pend_limit_r, sync_limit_r;

  state_t            state_r;
  logic              own_r, fm_valid_r, was_master_r;
  logic [ID_WIDTH-1:0] fm_r;
  logic [CNT_W-1:0]  pend_r, sync_r;
  logic [CW-1:0]     last_cnt_r, cnt_r;
  logic [IXW:0]      step_r;
  logic [ID_WIDTH-1:0] pid_r;
  logic [1:0]        pstate_r;
  logic              found_hit_r, found_free_r;
  logic [IXW-1:0]    hit_ix_r, free_ix_r;

  logic [ID_WIDTH-1:0] self_id;
  assign self_id = ID_WIDTH'(self_id_r);

  scan_t chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hit_v, free_v, valid_v, wr_en_v;
  logic wr_valid;
  logic start, shift;

  assign chain[0] = '0;
  assign start = state_r == ST_IDLE;
  assign shift = state_r == ST_SCAN;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      hme_cell #(.ID_W(ID_WIDTH)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (pid_r),
        .scan_in  (chain[g]),
        .start    (start),
        .shift    (shift && step_r == (IXW+1)'(g)),
        .wr_en    (wr_en_v[g]),
        .wr_valid (wr_valid),
        .scan_out (chain[g+1]),
        .my_hit   (hit_v[g]),
        .my_free  (free_v[g]),
        .valid    (valid_v[g])
      );
    end
  endgenerate

  // only the stepped cell can raise its hit or free flag, so an or over the
  // row gives this cycle's finding
  logic cur_hit, cur_free;
  always_comb begin
    cur_hit  = 1'b0;
    cur_free = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cur_hit  = cur_hit | hit_v[i];
      cur_free = cur_free | free_v[i];
    end
  end

  // write decision
  logic do_write;
  logic [IXW-1:0] wr_ix;
  always_comb begin
    do_write = 1'b0;
    wr_valid = 1'b1;
    wr_ix    = hit_ix_r;
    if (pstate_r == PEER_DESTROYED) begin
      do_write = found_hit_r;
      wr_valid = 1'b0;
    end else if (found_hit_r) begin
      do_write = 1'b1;
    end else if (found_free_r) begin
      do_write = 1'b1;
      wr_ix    = free_ix_r;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wr_en_v[i] = state_r == ST_WRITE && do_write && wr_ix == IXW'(i);
    end
  end

  logic [CW-1:0] nb_cnt;
  always_comb begin
    nb_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) nb_cnt = nb_cnt + CW'(valid_v[i]);
  end

  logic [61:0] ptime, stime;
  logic        is_self;
  logic        pready;
  assign ptime   = {in_peer_init_seconds, in_peer_init_nanos};
  assign stime   = {self_sec_r, self_nanos_r};
  assign is_self = in_peer_id == self_id;
  assign pready  = in_peer_state == PEER_READY;

  logic in_acc, out_acc;
  assign in_stall = state_r != ST_IDLE || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // election update for a peer item, done at acceptance
  logic              p_own, p_fmv, p_pub;
  logic [ID_WIDTH-1:0] p_fm;
  logic [CNT_W-1:0]  p_pend, p_sync;
  always_comb begin
    p_own  = own_r;
    p_fmv  = fm_valid_r;
    p_fm   = fm_r;
    p_pend = pend_r;
    p_sync = sync_r;
    p_pub  = 1'b0;
    if (!own_r) begin
      if (pready) begin
        p_own = 1'b1; p_fmv = in_peer_master_valid;
        p_fm  = in_peer_master_valid ? in_peer_master_id : '0;
        p_pend = '0; p_sync = '0; p_pub = 1'b1;
      end
    end else if (fm_valid_r && in_peer_id == fm_r) begin
      if (pready) begin
        p_sync = '0;
      end else begin
        p_own = 1'b0; p_fmv = 1'b0; p_fm = '0;
        p_pend = '0; p_sync = '0; p_pub = 1'b1;
      end
    end else if (pready && (in_peer_master_valid != fm_valid_r ||
                 (in_peer_master_valid && in_peer_master_id != fm_r))) begin
      if (ptime < stime) begin
        p_fmv = in_peer_master_valid;
        p_fm  = in_peer_master_valid ? in_peer_master_id : '0;
        p_pend = '0; p_sync = '0; p_pub = 1'b1;
      end
    end
  end

  // tick update
  logic              t_own, t_fmv, t_master;
  logic [ID_WIDTH-1:0] t_fm;
  logic [CNT_W-1:0]  t_pend, t_sync, inc;
  always_comb begin
    t_own  = own_r;
    t_fmv  = fm_valid_r;
    t_fm   = fm_r;
    t_pend = pend_r;
    t_sync = sync_r;
    inc    = '0;
    if (!own_r) begin
      inc = (pend_r != CNT_MAX) ? pend_r + 1'b1 : pend_r;
      t_pend = inc;
      if (inc >= pend_limit_r) begin
        t_pend = '0; t_own = 1'b1; t_fm = self_id; t_fmv = 1'b1;
      end
    end else if (!(fm_valid_r && fm_r == self_id)) begin
      inc = (sync_r != CNT_MAX) ? sync_r + 1'b1 : sync_r;
      t_sync = inc;
      if (inc >= sync_limit_r) begin
        t_sync = '0; t_own = 1'b0; t_fm = '0; t_fmv = 1'b0;
      end
    end
    t_master = t_fmv && t_fm == self_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= 16'd1;
      self_sec_r   <= '0;
      self_nanos_r <= '0;
      pend_limit_r <= 16'd5;
      sync_limit_r <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELF_ID:    self_id_r    <= cfg_data[15:0];
        REG_SELF_SEC:   self_sec_r   <= cfg_data;
        REG_SELF_NANOS: self_nanos_r <= cfg_data[29:0];
        REG_PEND_LIMIT: pend_limit_r <= cfg_data[15:0];
        REG_SYNC_LIMIT: sync_limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      own_r        <= 1'b0;
      fm_valid_r   <= 1'b0;
      fm_r         <= '0;
      pend_r       <= '0;
      sync_r       <= '0;
      was_master_r <= 1'b0;
      last_cnt_r   <= '0;
      out_valid    <= 1'b0;
      found_hit_r  <= 1'b0;
      found_free_r <= 1'b0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pid_r  <= in_peer_id;
            pstate_r <= in_peer_state;
            out_publish_status <= !in_mode || (!is_self && p_pub);
            out_replay_request <= !in_mode && t_master &&
              (!was_master_r || last_cnt_r != nb_cnt);
            out_table_overflow <= 1'b0;
            found_hit_r  <= 1'b0;
            found_free_r <= 1'b0;
            step_r <= '0;
            if (!in_mode) begin
              own_r <= t_own; fm_valid_r <= t_fmv; fm_r <= t_fm;
              pend_r <= t_pend; sync_r <= t_sync;
              was_master_r <= t_master;
              last_cnt_r   <= nb_cnt;
              state_r <= ST_OUT;
            end else if (is_self) begin
              state_r <= ST_OUT;
            end else begin
              own_r <= p_own; fm_valid_r <= p_fmv; fm_r <= p_fm;
              pend_r <= p_pend; sync_r <= p_sync;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit_v[i])  hit_ix_r  <= IXW'(i);
            if (free_v[i]) free_ix_r <= IXW'(i);
          end
          if (cur_hit)  found_hit_r  <= 1'b1;
          if (cur_free) found_free_r <= 1'b1;
          step_r <= step_r + 1'b1;
          if (step_r == (IXW+1)'(TABLE_DEPTH-1)) state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          out_table_overflow <= pstate_r != PEER_DESTROYED &&
                                !found_hit_r && !found_free_r;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          cnt_r     <= nb_cnt;
          out_valid <= 1'b1;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_node_state     = own_r;
  assign out_master_id      = fm_r;
  assign out_master_valid   = fm_valid_r;
  assign out_neighbor_count = 5'(cnt_r);

endmodule
